// File: design/mrz_check_digit_validator_assert.svh
// Assertion macros for the MRZ check-digit validator.
// Used by the top level; each macro expects signals clk and rst_n in scope.
`ifndef MRZ_CHECK_DIGIT_VALIDATOR_ASSERT_SVH
`define MRZ_CHECK_DIGIT_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRZCDV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrz check digit validator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MRZCDV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrz check digit validator: next-cycle check failed");

`endif

// File: design/mrzcdv_pkg.sv
// Package for the MRZ check-digit validator: types, constants and the
// small arithmetic helpers for 7-3-1 weighted sums mod 10. No dependencies.
`timescale 1ns / 1ps

package mrzcdv_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 6;
    localparam int LINE_W = 3;
    localparam int SUM_W  = 4;
    localparam int FLAG_W = 5;

    localparam logic [POS_W-1:0]  POS_MAX  = 6'd63;
    localparam logic [LINE_W-1:0] LINE_MAX = 3'd4;

    localparam logic [POS_W-1:0] TD1_LEN = 6'd30;
    localparam logic [POS_W-1:0] TD2_LEN = 6'd36;
    localparam logic [POS_W-1:0] TD3_LEN = 6'd44;

    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_P    = 8'h50;
    localparam logic [CHAR_W-1:0] CH_V    = 8'h56;

    // Bit positions inside the check flag vector.
    localparam int FLAG_NUMBER    = 0;
    localparam int FLAG_BIRTH     = 1;
    localparam int FLAG_EXPIRY    = 2;
    localparam int FLAG_PERSONAL  = 3;
    localparam int FLAG_COMPOSITE = 4;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_LINE_COUNT,
        STATUS_LENGTH,
        STATUS_FORMAT
    } status_t;

    typedef enum logic [2:0] {
        DOC_UNKNOWN,
        DOC_TD1,
        DOC_TD2,
        DOC_TD3,
        DOC_MRVA,
        DOC_MRVB
    } doc_type_t;

    // One decoded character as held in the input register. below_ten is set
    // for every character that is not a letter, whose full value is 0-9.
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic [SUM_W-1:0]  value_mod10;
        logic              below_ten;
        logic              line_end;
        logic              document_end;
    } char_item_t;

    // Document state after the current character, used for classification.
    typedef struct packed {
        logic [LINE_W-1:0] line_count;
        logic [POS_W-1:0]  first_line_length;
        logic              length_mismatch;
        logic [CHAR_W-1:0] leading_char;
        logic [FLAG_W-1:0] check_flags;
    } doc_summary_t;

    // Result item; the first member lands in the highest bits, so status
    // occupies bits 1:0 and composite_ok bit 9.
    typedef struct packed {
        logic      composite_ok;
        logic      personal_ok;
        logic      expiry_ok;
        logic      birth_ok;
        logic      number_ok;
        doc_type_t document_type;
        status_t   status;
    } result_t;

    // Character value mod 10: digits give their value, letters A-Z give
    // 10-35 reduced mod 10, anything else gives 0.
    function automatic logic [SUM_W-1:0] char_value_mod10(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        logic [SUM_W-1:0]  r;
        d = c - CH_A;
        r = '0;
        if (c inside {[CH_ZERO:CH_NINE]})
        begin
            r = SUM_W'(c - CH_ZERO);
        end
        else if (c inside {[CH_A:CH_Z]})
        begin
            if (d < 8'd10)
            begin
                r = d[SUM_W-1:0];
            end
            else if (d < 8'd20)
            begin
                r = SUM_W'(d - 8'd10);
            end
            else
            begin
                r = SUM_W'(d - 8'd20);
            end
        end
        return r;
    endfunction

    // Position mod 3 by folding base-4 digits (4 is 1 mod 3).
    function automatic logic [1:0] pos_mod3(input logic [POS_W-1:0] x);
        logic [3:0] s;
        logic [2:0] t;
        s = {2'b00, x[1:0]} + {2'b00, x[3:2]} + {2'b00, x[5:4]};
        t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
        return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    endfunction

    // (a + b) mod 3 for a, b in 0..2.
    function automatic logic [1:0] idx_add(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] t;
        t = {1'b0, a} + {1'b0, b};
        return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    endfunction

    // v * weight mod 10, with weight index 0, 1, 2 meaning 7, 3, 1.
    function automatic logic [SUM_W-1:0] mul_mod10(input logic [SUM_W-1:0] v,
                                                   input logic [1:0] idx);
        logic [SUM_W-1:0] r;
        r = v;
        if (idx == 2'd0)
        begin
            case (v)
                4'd0:    r = 4'd0;
                4'd1:    r = 4'd7;
                4'd2:    r = 4'd4;
                4'd3:    r = 4'd1;
                4'd4:    r = 4'd8;
                4'd5:    r = 4'd5;
                4'd6:    r = 4'd2;
                4'd7:    r = 4'd9;
                4'd8:    r = 4'd6;
                4'd9:    r = 4'd3;
                default: r = 4'd0;
            endcase
        end
        else if (idx == 2'd1)
        begin
            case (v)
                4'd0:    r = 4'd0;
                4'd1:    r = 4'd3;
                4'd2:    r = 4'd6;
                4'd3:    r = 4'd9;
                4'd4:    r = 4'd2;
                4'd5:    r = 4'd5;
                4'd6:    r = 4'd8;
                4'd7:    r = 4'd1;
                4'd8:    r = 4'd4;
                4'd9:    r = 4'd7;
                default: r = 4'd0;
            endcase
        end
        return r;
    endfunction

    // (sum + v * weight) mod 10.
    function automatic logic [SUM_W-1:0] add_weighted(input logic [SUM_W-1:0] sum,
                                                      input logic [SUM_W-1:0] v,
                                                      input logic [1:0] idx);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + {1'b0, mul_mod10(v, idx)};
        return (s >= 5'd10) ? SUM_W'(s - 5'd10) : s[SUM_W-1:0];
    endfunction

endpackage

// File: design/mrzcdv_decode.sv
// Input register of the MRZ check-digit validator: decodes each character
// to its value mod 10 and holds it for the field stage. Uses mrzcdv_pkg.
`timescale 1ns / 1ps

module mrzcdv_decode
    import mrzcdv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              line_end,
    input  logic              document_end,
    input  logic              advance,
    output logic              item_valid,
    output char_item_t        item
);

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;
    logic       take;

    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.char_code    <= char_code;
            item_reg.value_mod10  <= char_value_mod10(char_code);
            item_reg.below_ten    <= !(char_code inside {[CH_A:CH_Z]});
            item_reg.line_end     <= line_end;
            item_reg.document_end <= document_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/mrzcdv_fields.sv
// Document state of the MRZ check-digit validator: position and line
// tracking, the running weighted sums and the check flags. Uses mrzcdv_pkg.
`timescale 1ns / 1ps

module mrzcdv_fields
    import mrzcdv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         process,
    input  char_item_t   item,
    output doc_summary_t summary
);

    logic [POS_W-1:0]  char_position_reg, char_position_next;
    logic [LINE_W-1:0] line_count_reg, line_count_next;
    logic [POS_W-1:0]  first_line_length_reg, first_line_length_next;
    logic              length_mismatch_reg, length_mismatch_next;
    logic [CHAR_W-1:0] leading_char_reg, leading_char_next;
    logic [SUM_W-1:0]  number_sum_reg, number_sum_next;
    logic [SUM_W-1:0]  birth_sum_reg, birth_sum_next;
    logic [SUM_W-1:0]  expiry_sum_reg, expiry_sum_next;
    logic [SUM_W-1:0]  personal_sum_reg, personal_sum_next;
    logic [SUM_W-1:0]  composite_sum_reg, composite_sum_next;
    logic [1:0]        composite_phase_reg, composite_phase_next;
    logic [FLAG_W-1:0] check_flags_reg, check_flags_next;

    logic [POS_W-1:0] p;
    logic [POS_W:0]   p1;
    logic [POS_W:0]   len_ext;
    logic [1:0]       m3;
    logic [SUM_W-1:0] v;
    logic             line0;
    logic             line_td1;
    logic             line_other;
    logic             comp_len;
    logic             restart;
    logic [SUM_W-1:0] number_base;
    logic [SUM_W-1:0] composite_base;
    logic [1:0]       phase_base;
    logic             comp_add;
    logic [POS_W-1:0] line_len;

    always_comb
    begin
        p          = char_position_reg;
        p1         = {1'b0, p} + 7'd1;
        len_ext    = {1'b0, first_line_length_reg};
        m3         = pos_mod3(p);
        v          = item.value_mod10;
        line0      = (line_count_reg == 3'd0);
        line_td1   = (line_count_reg == 3'd1) && (first_line_length_reg == TD1_LEN);
        line_other = (line_count_reg == 3'd1) && (first_line_length_reg != TD1_LEN);
        comp_len   = (first_line_length_reg == TD2_LEN) || (first_line_length_reg == TD3_LEN);

        // The second line of a TD2/TD3/MRV document restarts the number and
        // composite sums, since line 0 gathered them in TD1 layout.
        restart        = line_other && (p == 6'd0);
        number_base    = restart ? '0 : number_sum_reg;
        composite_base = restart ? '0 : composite_sum_reg;
        phase_base     = restart ? 2'd0 : composite_phase_reg;

        number_sum_next      = number_base;
        birth_sum_next       = birth_sum_reg;
        expiry_sum_next      = expiry_sum_reg;
        personal_sum_next    = personal_sum_reg;
        composite_sum_next   = composite_base;
        composite_phase_next = phase_base;
        check_flags_next     = check_flags_reg;

        if (line0 && p >= 6'd5 && p <= 6'd13)
        begin
            number_sum_next = add_weighted(number_base, v, idx_add(m3, 2'd1));
        end
        if (line_other && p <= 6'd8)
        begin
            number_sum_next = add_weighted(number_base, v, m3);
        end

        if (line_td1 && p <= 6'd5)
        begin
            birth_sum_next = add_weighted(birth_sum_reg, v, m3);
        end
        if (line_other && p >= 6'd13 && p <= 6'd18)
        begin
            birth_sum_next = add_weighted(birth_sum_reg, v, idx_add(m3, 2'd2));
        end

        if (line_td1 && p >= 6'd8 && p <= 6'd13)
        begin
            expiry_sum_next = add_weighted(expiry_sum_reg, v, idx_add(m3, 2'd1));
        end
        if (line_other && p >= 6'd21 && p <= 6'd26)
        begin
            expiry_sum_next = add_weighted(expiry_sum_reg, v, m3);
        end

        if (line_other && p >= 6'd28 && p <= 6'd41)
        begin
            personal_sum_next = add_weighted(personal_sum_reg, v, idx_add(m3, 2'd2));
        end

        comp_add = (line0 && p >= 6'd5 && p <= 6'd29)
                || (line_td1 && (p <= 6'd6 || (p >= 6'd8 && p <= 6'd14)
                                 || (p >= 6'd18 && p <= 6'd28)))
                || (line_other && comp_len && (p <= 6'd9 || (p >= 6'd13 && p <= 6'd19)
                                               || (p >= 6'd21 && p1 < len_ext)));
        if (comp_add)
        begin
            composite_sum_next   = add_weighted(composite_base, v, phase_base);
            composite_phase_next = idx_add(phase_base, 2'd1);
        end

        // A check character matches when its full value equals the sum, so
        // a letter never matches while a filler or other symbol counts as 0.
        if ((line0 && p == 6'd14) || (line_other && p == 6'd9))
        begin
            check_flags_next[FLAG_NUMBER] = item.below_ten && (number_sum_reg == v);
        end
        if ((line_td1 && p == 6'd6) || (line_other && p == 6'd19))
        begin
            check_flags_next[FLAG_BIRTH] = item.below_ten && (birth_sum_reg == v);
        end
        if ((line_td1 && p == 6'd14) || (line_other && p == 6'd27))
        begin
            check_flags_next[FLAG_EXPIRY] = item.below_ten && (expiry_sum_reg == v);
        end
        if (line_other && p == 6'd42)
        begin
            check_flags_next[FLAG_PERSONAL] = item.below_ten && (personal_sum_reg == v);
        end
        if ((line_td1 && p == 6'd29) || (line_other && comp_len && p1 == len_ext))
        begin
            check_flags_next[FLAG_COMPOSITE] = item.below_ten && (composite_sum_reg == v);
        end

        leading_char_next = leading_char_reg;
        if (line0 && p == 6'd0)
        begin
            leading_char_next = item.char_code;
        end

        // Line bookkeeping; the document end also closes the current line.
        line_len               = (p == POS_MAX) ? POS_MAX : p + 6'd1;
        char_position_next     = char_position_reg;
        line_count_next        = line_count_reg;
        first_line_length_next = first_line_length_reg;
        length_mismatch_next   = length_mismatch_reg;
        if (item.line_end || item.document_end)
        begin
            if (line0)
            begin
                first_line_length_next = line_len;
            end
            else if (line_len != first_line_length_reg)
            begin
                length_mismatch_next = 1'b1;
            end
            if (line_count_reg < LINE_MAX)
            begin
                line_count_next = line_count_reg + 3'd1;
            end
            char_position_next = '0;
        end
        else if (char_position_reg < POS_MAX)
        begin
            char_position_next = char_position_reg + 6'd1;
        end
    end

    assign summary.line_count        = line_count_next;
    assign summary.first_line_length = first_line_length_next;
    assign summary.length_mismatch   = length_mismatch_next;
    assign summary.leading_char      = leading_char_next;
    assign summary.check_flags       = check_flags_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_position_reg     <= '0;
            line_count_reg        <= '0;
            first_line_length_reg <= '0;
            length_mismatch_reg   <= 1'b0;
            leading_char_reg      <= '0;
            number_sum_reg        <= '0;
            birth_sum_reg         <= '0;
            expiry_sum_reg        <= '0;
            personal_sum_reg      <= '0;
            composite_sum_reg     <= '0;
            composite_phase_reg   <= '0;
            check_flags_reg       <= '0;
        end
        else if (process)
        begin
            if (item.document_end)
            begin
                char_position_reg     <= '0;
                line_count_reg        <= '0;
                first_line_length_reg <= '0;
                length_mismatch_reg   <= 1'b0;
                leading_char_reg      <= '0;
                number_sum_reg        <= '0;
                birth_sum_reg         <= '0;
                expiry_sum_reg        <= '0;
                personal_sum_reg      <= '0;
                composite_sum_reg     <= '0;
                composite_phase_reg   <= '0;
                check_flags_reg       <= '0;
            end
            else
            begin
                char_position_reg     <= char_position_next;
                line_count_reg        <= line_count_next;
                first_line_length_reg <= first_line_length_next;
                length_mismatch_reg   <= length_mismatch_next;
                leading_char_reg      <= leading_char_next;
                number_sum_reg        <= number_sum_next;
                birth_sum_reg         <= birth_sum_next;
                expiry_sum_reg        <= expiry_sum_next;
                personal_sum_reg      <= personal_sum_next;
                composite_sum_reg     <= composite_sum_next;
                composite_phase_reg   <= composite_phase_next;
                check_flags_reg       <= check_flags_next;
            end
        end
    end

endmodule

// File: design/mrzcdv_result.sv
// Result stage of the MRZ check-digit validator: classifies the finished
// document and holds the result item until taken. Uses mrzcdv_pkg.
`timescale 1ns / 1ps

module mrzcdv_result
    import mrzcdv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  doc_summary_t summary,
    input  logic         out_ready,
    output logic         out_valid,
    output result_t      result
);

    logic      valid_reg;
    logic      valid_next;
    result_t   result_reg;
    result_t   result_next;
    status_t   status;
    doc_type_t doc_type;
    logic      two_lines;
    logic      three_lines;
    logic      ok;

    always_comb
    begin
        two_lines   = (summary.line_count == 3'd2);
        three_lines = (summary.line_count == 3'd3);
        status      = STATUS_OK;
        doc_type    = DOC_UNKNOWN;
        if (!two_lines && !three_lines)
        begin
            status = STATUS_LINE_COUNT;
        end
        else if (summary.length_mismatch)
        begin
            status = STATUS_LENGTH;
        end
        else if (three_lines && summary.first_line_length == TD1_LEN)
        begin
            doc_type = DOC_TD1;
        end
        else if (two_lines && summary.first_line_length == TD3_LEN)
        begin
            doc_type = (summary.leading_char == CH_P) ? DOC_TD3 : DOC_MRVA;
        end
        else if (two_lines && summary.first_line_length == TD2_LEN)
        begin
            doc_type = (summary.leading_char == CH_V) ? DOC_MRVB : DOC_TD2;
        end
        else
        begin
            status = STATUS_FORMAT;
        end

        ok = (status == STATUS_OK);
        result_next.status        = status;
        result_next.document_type = doc_type;
        result_next.number_ok     = ok && summary.check_flags[FLAG_NUMBER];
        result_next.birth_ok      = ok && summary.check_flags[FLAG_BIRTH];
        result_next.expiry_ok     = ok && summary.check_flags[FLAG_EXPIRY];
        result_next.personal_ok   = ok && (doc_type == DOC_TD3)
                                    && summary.check_flags[FLAG_PERSONAL];
        result_next.composite_ok  = ok && (doc_type inside {DOC_TD1, DOC_TD2, DOC_TD3})
                                    && summary.check_flags[FLAG_COMPOSITE];

        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

// File: design/mrz_check_digit_validator.sv
// MRZ check-digit validator (ICAO 9303, 7-3-1 weights mod 10). Characters of
// a machine-readable zone arrive one per input transaction, with tuser
// marking the last character of a line and tlast the last character of the
// document; the document end also closes its line. The block counts lines,
// keeps the first line's length (saturating at 63) and leading character,
// and keeps running check sums for the document number, birth date, expiry
// date, personal number and composite. On the document end it emits one
// result transaction with the status, the document type (TD1, TD2, TD3,
// MRVA, MRVB) and the per-field check results, then starts a fresh document.
// TD1 composite weights run continuously over both lines. Throughput is one
// character per clock: each character passes an input register and the field
// logic and, on a document end, the result register, which is loaded from
// the field logic as the character leaves the input register. Input is only
// held back while a finished result waits on the output side with a full
// input register behind it. Depends on mrzcdv_pkg and the assertion header.
`timescale 1ns / 1ps

`include "mrz_check_digit_validator_assert.svh"

module mrz_check_digit_validator
    import mrzcdv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] line_end
    input  logic        s_axis_tlast,   // document_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [1:0] status, [4:2] document_type,
                                        // [5] number_ok, [6] birth_ok,
                                        // [7] expiry_ok, [8] personal_ok,
                                        // [9] composite_ok, [15:10] zero
);

    localparam int RESULT_W = $bits(result_t);

    logic         item_valid;
    char_item_t   item;
    logic         out_free;
    logic         process;
    logic         load;
    doc_summary_t summary;
    result_t      result;

    // The field stage advances whenever the result register can take a new
    // value, which keeps the state update and the result strictly in order.
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign process  = item_valid && out_free;
    assign load     = process && item.document_end;

    mrzcdv_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .char_code    (s_axis_tdata),
        .line_end     (s_axis_tuser),
        .document_end (s_axis_tlast),
        .advance      (process),
        .item_valid   (item_valid),
        .item         (item)
    );

    mrzcdv_fields u_fields
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .process (process),
        .item    (item),
        .summary (summary)
    );

    mrzcdv_result u_result
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .summary   (summary),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .result    (result)
    );

    assign m_axis_tdata = {(16 - RESULT_W)'(0), result};

    // Every document end that is processed produces a result.
    `MRZCDV_ASSERT_NEXT(a_eod_gives_result, load, m_axis_tvalid)

    // A new result only appears after a processed document end.
    `MRZCDV_ASSERT_SAME(a_result_from_eod, $rose(m_axis_tvalid), $past(load))

    // A failing status carries no type and no check results.
    `MRZCDV_ASSERT_SAME(a_fail_clears_fields,
        m_axis_tvalid && result.status != STATUS_OK,
        result.document_type == DOC_UNKNOWN && result.number_ok == 1'b0
        && result.birth_ok == 1'b0 && result.expiry_ok == 1'b0
        && result.personal_ok == 1'b0 && result.composite_ok == 1'b0)

    // A passing status always names a document type.
    `MRZCDV_ASSERT_SAME(a_ok_has_type,
        m_axis_tvalid && result.status == STATUS_OK,
        result.document_type != DOC_UNKNOWN)

endmodule

// File: bench/mrz_result_checker.sv
// Result checker for the MRZ check-digit validator testbench: follows both
// stream channels, predicts each document result and compares it.
// Depends on mrzcdv_pkg for the status and document type encodings.
`timescale 1ns / 1ps

module mrz_result_checker
    import mrzcdv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    output int          mismatches,
    output int          outstanding
);

    // Running document state, mirroring what the block keeps per document.
    logic [5:0] char_pos;
    logic [2:0] line_cnt;
    logic [5:0] first_len;
    logic       len_mismatch;
    logic [7:0] lead_char;
    logic [3:0] num_sum;
    logic [3:0] birth_sum;
    logic [3:0] exp_sum;
    logic [3:0] pers_sum;
    logic [3:0] comp_sum;
    logic [1:0] comp_phase;
    logic [4:0] flags;

    result_t expected_results[$];
    int      results_seen;

    function automatic int glyph_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - "0";
        end
        if (c >= "A" && c <= "Z")
        begin
            return c - "A" + 10;
        end
        return 0;
    endfunction

    // Adds v times the 7-3-1 weight selected by k to a mod-10 sum.
    function automatic logic [3:0] sum_add(input logic [3:0] s, input int v, input int k);
        int w;
        case (k % 3)
            0:       w = 7;
            1:       w = 3;
            default: w = 1;
        endcase
        return 4'((s + v * w) % 10);
    endfunction

    task automatic clear_doc();
        char_pos     = '0;
        line_cnt     = '0;
        first_len    = '0;
        len_mismatch = 1'b0;
        lead_char    = '0;
        num_sum      = '0;
        birth_sum    = '0;
        exp_sum      = '0;
        pers_sum     = '0;
        comp_sum     = '0;
        comp_phase   = '0;
        flags        = '0;
    endtask

    task automatic comp_step(input int v);
        comp_sum   = sum_add(comp_sum, v, comp_phase);
        comp_phase = (comp_phase == 2'd2) ? 2'd0 : comp_phase + 2'd1;
    endtask

    // Second line of a document whose first line is not TD1 sized.
    task automatic fold_long_line(input int p, input int v);
        int len;
        len = first_len;
        if (p == 0)
        begin
            num_sum    = '0;
            comp_sum   = '0;
            comp_phase = '0;
        end
        if (p <= 8) num_sum = sum_add(num_sum, v, p);
        if (p == 9) flags[FLAG_NUMBER] = (num_sum == v);
        if (p >= 13 && p <= 18) birth_sum = sum_add(birth_sum, v, p - 13);
        if (p == 19) flags[FLAG_BIRTH] = (birth_sum == v);
        if (p >= 21 && p <= 26) exp_sum = sum_add(exp_sum, v, p - 21);
        if (p == 27) flags[FLAG_EXPIRY] = (exp_sum == v);
        if (p >= 28 && p <= 41) pers_sum = sum_add(pers_sum, v, p - 28);
        if (p == 42) flags[FLAG_PERSONAL] = (pers_sum == v);
        if (len == TD2_LEN || len == TD3_LEN)
        begin
            if (p <= 9 || (p >= 13 && p <= 19) || (p >= 21 && p + 1 < len)) comp_step(v);
            if (p + 1 == len) flags[FLAG_COMPOSITE] = (comp_sum == v);
        end
    endtask

    // Folds one accepted character into the document state; on the document
    // end it yields the expected result and starts a fresh document.
    task automatic fold_char(input logic [7:0] c, input logic eol, input logic eod,
                             output logic done, output result_t res);
        int        p;
        int        v;
        int        len;
        status_t   st;
        doc_type_t dt;
        p    = char_pos;
        v    = glyph_value(c);
        done = eod;
        res  = '0;
        if (line_cnt == 0)
        begin
            if (p == 0) lead_char = c;
            if (p >= 5 && p <= 13) num_sum = sum_add(num_sum, v, p - 5);
            if (p == 14) flags[FLAG_NUMBER] = (num_sum == v);
            if (p >= 5 && p <= 29) comp_step(v);
        end
        else if (line_cnt == 1 && first_len == TD1_LEN)
        begin
            if (p <= 5) birth_sum = sum_add(birth_sum, v, p);
            if (p == 6) flags[FLAG_BIRTH] = (birth_sum == v);
            if (p >= 8 && p <= 13) exp_sum = sum_add(exp_sum, v, p - 8);
            if (p == 14) flags[FLAG_EXPIRY] = (exp_sum == v);
            if (p <= 6 || (p >= 8 && p <= 14) || (p >= 18 && p <= 28)) comp_step(v);
            if (p == 29) flags[FLAG_COMPOSITE] = (comp_sum == v);
        end
        else if (line_cnt == 1)
        begin
            fold_long_line(p, v);
        end

        if (eol || eod)
        begin
            len = (p >= 63) ? 63 : p + 1;
            if (line_cnt == 0) first_len = 6'(len);
            else if (len != first_len) len_mismatch = 1'b1;
            if (line_cnt < LINE_MAX) line_cnt = line_cnt + 3'd1;
            char_pos = '0;
        end
        else if (char_pos < POS_MAX)
        begin
            char_pos = char_pos + 6'd1;
        end

        if (eod)
        begin
            st = STATUS_OK;
            dt = DOC_UNKNOWN;
            if (line_cnt != 2 && line_cnt != 3) st = STATUS_LINE_COUNT;
            else if (len_mismatch) st = STATUS_LENGTH;
            else if (line_cnt == 3 && first_len == TD1_LEN) dt = DOC_TD1;
            else if (line_cnt == 2 && first_len == TD3_LEN)
                dt = (lead_char == CH_P) ? DOC_TD3 : DOC_MRVA;
            else if (line_cnt == 2 && first_len == TD2_LEN)
                dt = (lead_char == CH_V) ? DOC_MRVB : DOC_TD2;
            else st = STATUS_FORMAT;
            res.status        = st;
            res.document_type = dt;
            if (st == STATUS_OK)
            begin
                res.number_ok    = flags[FLAG_NUMBER];
                res.birth_ok     = flags[FLAG_BIRTH];
                res.expiry_ok    = flags[FLAG_EXPIRY];
                res.personal_ok  = flags[FLAG_PERSONAL] && (dt == DOC_TD3);
                res.composite_ok = flags[FLAG_COMPOSITE] &&
                                   (dt == DOC_TD1 || dt == DOC_TD2 || dt == DOC_TD3);
            end
            clear_doc();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic compare_result(input logic [15:0] data);
        result_t got;
        result_t want;
        got = result_t'(data[9:0]);
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result transaction 0x%04h with no document pending",
                                      data));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      results_seen, got.status, want.status));
        if (got.document_type !== want.document_type)
            report_mismatch($sformatf("result %0d: document_type %0d, expected %0d",
                                      results_seen, got.document_type, want.document_type));
        if (got.number_ok !== want.number_ok)
            report_mismatch($sformatf("result %0d: number_ok %b, expected %b",
                                      results_seen, got.number_ok, want.number_ok));
        if (got.birth_ok !== want.birth_ok)
            report_mismatch($sformatf("result %0d: birth_ok %b, expected %b",
                                      results_seen, got.birth_ok, want.birth_ok));
        if (got.expiry_ok !== want.expiry_ok)
            report_mismatch($sformatf("result %0d: expiry_ok %b, expected %b",
                                      results_seen, got.expiry_ok, want.expiry_ok));
        if (got.personal_ok !== want.personal_ok)
            report_mismatch($sformatf("result %0d: personal_ok %b, expected %b",
                                      results_seen, got.personal_ok, want.personal_ok));
        if (got.composite_ok !== want.composite_ok)
            report_mismatch($sformatf("result %0d: composite_ok %b, expected %b",
                                      results_seen, got.composite_ok, want.composite_ok));
        if (data[15:10] !== 6'd0)
            report_mismatch($sformatf("result %0d: padding bits 0x%02h, expected zero",
                                      results_seen, data[15:10]));
    endtask

    // Both channels are sampled at the clock edge, before any driver updates.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        logic    done;
        result_t res;
        if (!rst_n)
        begin
            clear_doc();
            expected_results.delete();
            mismatches   = 0;
            outstanding  = 0;
            results_seen = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                fold_char(s_axis_tdata, s_axis_tuser, s_axis_tlast, done, res);
                if (done) expected_results = {expected_results, res};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                compare_result(m_axis_tdata);
                results_seen++;
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// File: bench/tb_top.sv
// Top of the MRZ check-digit validator testbench: clock, reset, character
// stimulus and the final verdict. Depends on mrzcdv_pkg, the validator RTL
// and the mrz_result_checker module, which predicts and compares results.
`timescale 1ns / 1ps

module tb_top;
    import mrzcdv_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    // The limit leaves a wide margin over the slowest correct run, to allow
    // for the stalls of both sides.
    localparam int CYCLE_LIMIT  = 200000;
    // A result comes out of the result register after its last character has
    // passed the input register; the tail wait leaves a margin over that.
    localparam int TAIL_CYCLES  = 16;
    localparam int PHASE_ITEMS  = 420;
    localparam int PHASE_DOCS   = 5;
    localparam int MAX_LINES    = 5;
    localparam int MAX_LINE_LEN = 70;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] char_code
    logic        s_axis_tuser  = 1'b0;    // [0] line_end
    logic        s_axis_tlast  = 1'b0;    // document_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [1:0] status, [4:2] document_type,
                                          // [5] number_ok ... [9] composite_ok

    int mismatches;
    int outstanding;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int chars_sent    = 0;
    int docs_sent     = 0;

    // The document being sent: up to five lines of up to seventy characters.
    logic [7:0] doc_text [0:MAX_LINES-1][0:MAX_LINE_LEN-1];
    int         line_len [0:MAX_LINES-1];
    int         n_lines;
    // Characters of the field whose check character is placed next.
    logic [7:0] field_chars[$];

    always #(CLK_PERIOD / 2) clk = ~clk;

    mrz_check_digit_validator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mrz_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // The result side stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: no progress after %0d cycles", cycle_count);
            $display("mrz_check_digit_validator: mismatch");
            $finish;
        end
    end

    // Offers one character and returns at the edge where the transaction is
    // taken. Random idle cycles go in front of it, so that the gaps land at
    // every position within a line and a document.
    task automatic send_char(input logic [7:0] code, input logic eol, input logic eod);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= eol;
        s_axis_tlast  <= eod;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        chars_sent++;
        if (eod) docs_sent++;
    endtask

    // Holds the input side quiet until every document result has come back.
    // It always lets at least one edge pass, so that the valid line is never
    // driven twice in one time step.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    function automatic int glyph_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return c - "0";
        end
        if (c >= "A" && c <= "Z")
        begin
            return c - "A" + 10;
        end
        return 0;
    endfunction

    // Mostly digits, letters and fillers, now and then any byte at all.
    function automatic logic [7:0] random_mrz_char();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 8'("0" + $urandom_range(9));
        if (r < 80) return 8'("A" + $urandom_range(25));
        if (r < 95) return "<";
        return 8'($urandom_range(255));
    endfunction

    // Line lengths: mostly short, some around the three document widths,
    // a few near or past the point where the block's length count saturates.
    function automatic int pick_len();
        int near_sizes[9];
        int r;
        near_sizes = '{29, 30, 31, 35, 36, 37, 43, 44, 45};
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(1, 12);
        if (r < 90) return near_sizes[$urandom_range(8)];
        return $urandom_range(60, MAX_LINE_LEN);
    endfunction

    task automatic gather(input int ln, input int lo, input int hi);
        int j;
        for (j = lo; j <= hi; j++)
        begin
            field_chars = {field_chars, doc_text[ln][j]};
        end
    endtask

    // Writes the 7-3-1 check character of the gathered field at (ln, pos).
    // One time in five a random digit or letter goes there instead, so both
    // outcomes of every check come up.
    task automatic place_check(input int ln, input int pos);
        int total;
        int i;
        int w;
        total = 0;
        for (i = 0; i < field_chars.size(); i++)
        begin
            case (i % 3)
                0:       w = 7;
                1:       w = 3;
                default: w = 1;
            endcase
            total = (total + glyph_value(field_chars[i]) * w) % 10;
        end
        if ($urandom_range(99) < 80)
            doc_text[ln][pos] = 8'("0" + total);
        else if ($urandom_range(1) == 1)
            doc_text[ln][pos] = 8'("0" + $urandom_range(9));
        else
            doc_text[ln][pos] = 8'("A" + $urandom_range(25));
        field_chars.delete();
    endtask

    // Builds a properly shaped document of the given kind with random content.
    task automatic build_wellformed(input doc_type_t kind);
        int len;
        int ln;
        int j;
        len     = (kind == DOC_TD1) ? 30 : (kind == DOC_TD3 || kind == DOC_MRVA) ? 44 : 36;
        n_lines = (kind == DOC_TD1) ? 3 : 2;
        for (ln = 0; ln < n_lines; ln++)
        begin
            line_len[ln] = len;
            for (j = 0; j < len; j++)
            begin
                doc_text[ln][j] = random_mrz_char();
            end
        end
        // The leading character separates passports and visas.
        case (kind)
            DOC_TD3:  doc_text[0][0] = CH_P;
            DOC_MRVA: doc_text[0][0] = ($urandom_range(1) == 1) ? CH_V : "A";
            DOC_MRVB: doc_text[0][0] = CH_V;
            DOC_TD2:  doc_text[0][0] = ($urandom_range(1) == 1) ? "I" : "C";
            default:  doc_text[0][0] = "I";
        endcase
        if (kind == DOC_TD1)
        begin
            gather(0, 5, 13);
            place_check(0, 14);
            gather(1, 0, 5);
            place_check(1, 6);
            gather(1, 8, 13);
            place_check(1, 14);
            // The TD1 composite runs over both lines with continuous weights.
            gather(0, 5, 29);
            gather(1, 0, 6);
            gather(1, 8, 14);
            gather(1, 18, 28);
            place_check(1, 29);
        end
        else
        begin
            gather(1, 0, 8);
            place_check(1, 9);
            gather(1, 13, 18);
            place_check(1, 19);
            gather(1, 21, 26);
            place_check(1, 27);
            if (len == 44)
            begin
                gather(1, 28, 41);
                place_check(1, 42);
            end
            gather(1, 0, 9);
            gather(1, 13, 19);
            gather(1, 21, len - 2);
            place_check(1, len - 1);
        end
    endtask

    // Builds a document of random shape: any line count up to five, lines
    // that mostly share the first line's length, random characters.
    task automatic build_malformed();
        int ln;
        int j;
        n_lines     = $urandom_range(1, MAX_LINES);
        line_len[0] = pick_len();
        for (ln = 0; ln < n_lines; ln++)
        begin
            if (ln > 0)
                line_len[ln] = ($urandom_range(99) < 70) ? line_len[0] : pick_len();
            for (j = 0; j < line_len[ln]; j++)
            begin
                doc_text[ln][j] = random_mrz_char();
            end
        end
        case ($urandom_range(2))
            0:       doc_text[0][0] = CH_P;
            1:       doc_text[0][0] = CH_V;
            default: doc_text[0][0] = 8'($urandom_range(255));
        endcase
    endtask

    // Streams the built document. The last character carries the document
    // end, with or without the line end mark, since either closes the line.
    task automatic send_document();
        int   ln;
        int   j;
        logic eol;
        logic eod;
        for (ln = 0; ln < n_lines; ln++)
        begin
            for (j = 0; j < line_len[ln]; j++)
            begin
                eol = (j == line_len[ln] - 1);
                eod = eol && (ln == n_lines - 1);
                if (eod) eol = ($urandom_range(1) == 1);
                send_char(doc_text[ln][j], eol, eod);
            end
        end
    endtask

    // Short hand-made documents for the corner cases of classification.
    task automatic run_directed();
        // A single character that is also the whole document: one line.
        send_char(8'hFF, 1'b0, 1'b1);
        // Two one-character lines of equal length: shape not recognized.
        send_char(8'h00, 1'b1, 1'b0);
        send_char("Z", 1'b1, 1'b1);
        // The document end closes a shorter second line: unequal lengths.
        send_char(CH_P, 1'b0, 1'b0);
        send_char("<", 1'b1, 1'b0);
        send_char("9", 1'b0, 1'b1);
        // Five lines: the line count stops at four.
        send_char("A", 1'b1, 1'b0);
        send_char("0", 1'b1, 1'b0);
        send_char("9", 1'b1, 1'b0);
        send_char("<", 1'b1, 1'b0);
        send_char(8'h80, 1'b1, 1'b1);
        // Three equal lines that are too short for TD1.
        send_char(CH_V, 1'b0, 1'b0);
        send_char("1", 1'b1, 1'b0);
        send_char("B", 1'b0, 1'b0);
        send_char("8", 1'b1, 1'b0);
        send_char("z", 1'b0, 1'b0);
        send_char("7", 1'b1, 1'b1);
        // Two equal lines, the second closed by the document end alone.
        send_char("I", 1'b0, 1'b0);
        send_char("<", 1'b1, 1'b0);
        send_char("C", 1'b0, 1'b0);
        send_char("D", 1'b0, 1'b1);
    endtask

    // Random documents until the phase has both enough characters and enough
    // results. Half of them are well shaped, the rest are random shapes.
    task automatic run_random(input bit every_kind_first);
        int items_start;
        int docs_start;
        int k;
        items_start = chars_sent;
        docs_start  = docs_sent;
        if (every_kind_first)
        begin
            for (k = 1; k <= 5; k++)
            begin
                build_wellformed(doc_type_t'(k));
                send_document();
            end
        end
        while (chars_sent - items_start < PHASE_ITEMS || docs_sent - docs_start < PHASE_DOCS)
        begin
            if ($urandom_range(99) < 50)
                build_wellformed(doc_type_t'($urandom_range(1, 5)));
            else
                build_malformed();
            send_document();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // First phase: the sender idles 37 percent of the time and the
        // receiver 74 percent; the directed documents run in this phase.
        send_idle_pct = 37;
        recv_idle_pct = 74;
        run_directed();
        drain();
        run_random(1'b1);
        drain();

        // Second phase: the rates swap.
        send_idle_pct = 74;
        recv_idle_pct = 37;
        run_random(1'b0);
        drain();

        // Third phase: both sides run at full rate.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(1'b0);
        drain();

        // Any stray result transaction would show up within this window.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("mrz_check_digit_validator: match");
        end
        else
        begin
            $display("mrz_check_digit_validator: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/mrzcdv_pkg.sv
design/mrzcdv_decode.sv
design/mrzcdv_fields.sv
design/mrzcdv_result.sv
design/mrz_check_digit_validator.sv
bench/mrz_result_checker.sv
bench/tb_top.sv
